### rtl/core/tdhd_pkg.sv
package tdhd_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = SAMPLE_W + 1;
    localparam int THRESH_W    = 16;
    localparam int LIMIT_W     = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int NUM_AXES    = 3;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 8;

    localparam int COUNTER_WIDTH_DEFAULT = 8;

    localparam logic [THRESH_W-1:0] ENTER_AXIS_RESET = 16'd11468;
    localparam logic [THRESH_W-1:0] EXIT_Z_RESET     = 16'd13107;
    localparam logic [THRESH_W-1:0] EXIT_XY_RESET    = 16'd9830;
    localparam logic [LIMIT_W-1:0]  ENTER_LIMIT_RESET = 8'd5;
    localparam logic [LIMIT_W-1:0]  EXIT_LIMIT_RESET  = 8'd20;

    localparam logic [CFG_INDEX_W-1:0] REG_ENTER_AXIS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXIT_Z      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EXIT_XY     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTER_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_EXIT_LIMIT  = 3'd4;

    typedef enum logic [1:0] {
        CLASS_BETWEEN = 2'd0,
        CLASS_TILTED  = 2'd1,
        CLASS_NORMAL  = 2'd2
    } sample_class_t;

    // compare results of one axis lane
    typedef struct packed {
        logic gt_enter;
        logic lt_enter;
        logic ge_exit;
        logic le_exit;
    } lane_cmp_t;

    typedef struct packed {
        logic          tilted_flag;
        logic          tilt_entered;
        logic          tilt_cleared;
        sample_class_t sample_class;
    } tilt_result_t;

endpackage

### rtl/core/tdhd_axis_lane.sv
module tdhd_axis_lane
    import tdhd_pkg::*;
(
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic        [THRESH_W-1:0] enter_thresh,
    input  logic        [THRESH_W-1:0] exit_thresh,
    output lane_cmp_t                  cmp
);

    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] enter_ext;
    logic [MAG_W-1:0] exit_ext;

    // most negative sample yields 2^15, hence the extra bit
    always_comb begin
        if (sample[SAMPLE_W-1]) begin
            mag = (MAG_W'(1) << SAMPLE_W) - {1'b0, sample};
        end else begin
            mag = {1'b0, sample};
        end
    end

    assign enter_ext = MAG_W'(enter_thresh);
    assign exit_ext  = MAG_W'(exit_thresh);

    assign cmp.gt_enter = (mag >  enter_ext);
    assign cmp.lt_enter = (mag <  enter_ext);
    assign cmp.ge_exit  = (mag >= exit_ext);
    assign cmp.le_exit  = (mag <= exit_ext);

endmodule

### rtl/core/tdhd_merge.sv
module tdhd_merge
    import tdhd_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  lane_cmp_t          cmp_x,
    input  lane_cmp_t          cmp_y,
    input  lane_cmp_t          cmp_z,
    input  logic [LIMIT_W-1:0] enter_limit,
    input  logic [LIMIT_W-1:0] exit_limit,
    output tilt_result_t       result
);

    localparam int CMP_W = (COUNTER_WIDTH > LIMIT_W) ? COUNTER_WIDTH : LIMIT_W;
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

    logic                     tilt_reg, tilt_next;
    logic [COUNTER_WIDTH-1:0] enter_cnt_reg, enter_cnt_next;
    logic [COUNTER_WIDTH-1:0] exit_cnt_reg, exit_cnt_next;

    logic          is_tilted;
    logic          is_normal;
    sample_class_t cls;
    logic [CMP_W-1:0] enter_lim_ext, exit_lim_ext;
    logic [CMP_W-1:0] enter_bumped_ext, exit_bumped_ext;
    logic [COUNTER_WIDTH-1:0] enter_bumped, exit_bumped;

    // tilted wins over normal when thresholds overlap
    assign is_tilted = cmp_z.lt_enter | cmp_x.gt_enter | cmp_y.gt_enter;
    assign is_normal = cmp_z.ge_exit & cmp_x.le_exit & cmp_y.le_exit;

    always_comb begin
        if (is_tilted) begin
            cls = CLASS_TILTED;
        end else if (is_normal) begin
            cls = CLASS_NORMAL;
        end else begin
            cls = CLASS_BETWEEN;
        end
    end

    assign enter_lim_ext = CMP_W'(enter_limit);
    assign exit_lim_ext  = CMP_W'(exit_limit);

    // saturate at the limit and at the counter maximum
    always_comb begin
        enter_bumped = enter_cnt_reg;
        if ((CMP_W'(enter_cnt_reg) < enter_lim_ext) && (enter_cnt_reg != CNT_MAX)) begin
            enter_bumped = enter_cnt_reg + COUNTER_WIDTH'(1);
        end
        exit_bumped = exit_cnt_reg;
        if ((CMP_W'(exit_cnt_reg) < exit_lim_ext) && (exit_cnt_reg != CNT_MAX)) begin
            exit_bumped = exit_cnt_reg + COUNTER_WIDTH'(1);
        end
    end

    assign enter_bumped_ext = CMP_W'(enter_bumped);
    assign exit_bumped_ext  = CMP_W'(exit_bumped);

    always_comb begin
        tilt_next      = tilt_reg;
        enter_cnt_next = enter_cnt_reg;
        exit_cnt_next  = exit_cnt_reg;
        result.tilt_entered = 1'b0;
        result.tilt_cleared = 1'b0;
        case (cls)
            CLASS_TILTED: begin
                exit_cnt_next  = '0;
                enter_cnt_next = enter_bumped;
                if (!tilt_reg && (enter_bumped_ext >= enter_lim_ext)) begin
                    tilt_next           = 1'b1;
                    result.tilt_entered = 1'b1;
                end
            end
            CLASS_NORMAL: begin
                enter_cnt_next = '0;
                exit_cnt_next  = exit_bumped;
                if (tilt_reg && (exit_bumped_ext >= exit_lim_ext)) begin
                    tilt_next           = 1'b0;
                    result.tilt_cleared = 1'b1;
                end
            end
            default: begin
                enter_cnt_next = '0;
                exit_cnt_next  = '0;
            end
        endcase
        result.tilted_flag  = tilt_next;
        result.sample_class = cls;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tilt_reg      <= 1'b0;
            enter_cnt_reg <= '0;
            exit_cnt_reg  <= '0;
        end else if (advance) begin
            tilt_reg      <= tilt_next;
            enter_cnt_reg <= enter_cnt_next;
            exit_cnt_reg  <= exit_cnt_next;
        end
    end

endmodule

### rtl/core/tilt_detect_hysteresis_debounce_unit.sv
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tdata: accel_x, accel_y, accel_z
// m_        out  m_tvalid/m_tready    m_tdata: flag, entered, cleared, class
// cfg_      in   cfg_wr_en            cfg_index, cfg_wdata
//
// One sample per cycle sustained while m_tready stays high.
// Stage one registers the three axis-lane compares, stage two classifies,
// runs the debounce counters and loads the output register.
// Synchronous active-low reset clears the pipeline, counters, flag and
// restores the register defaults. A stalled result holds; the compare stage
// keeps taking requests while the output register can drain.
module tilt_detect_hysteresis_debounce_unit
    import tdhd_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
    input  logic [IN_DATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] tilted_flag, [1] tilt_entered, [2] tilt_cleared, [4:3] sample_class
    output logic [OUT_DATA_W-1:0]  m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic [THRESH_W-1:0] enter_axis_reg, exit_z_reg, exit_xy_reg;
    logic [LIMIT_W-1:0]  enter_limit_reg, exit_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enter_axis_reg  <= ENTER_AXIS_RESET;
            exit_z_reg      <= EXIT_Z_RESET;
            exit_xy_reg     <= EXIT_XY_RESET;
            enter_limit_reg <= ENTER_LIMIT_RESET;
            exit_limit_reg  <= EXIT_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ENTER_AXIS:  enter_axis_reg  <= cfg_wdata[THRESH_W-1:0];
                REG_EXIT_Z:      exit_z_reg      <= cfg_wdata[THRESH_W-1:0];
                REG_EXIT_XY:     exit_xy_reg     <= cfg_wdata[THRESH_W-1:0];
                REG_ENTER_LIMIT: enter_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_EXIT_LIMIT:  exit_limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    lane_cmp_t cmp_x, cmp_y, cmp_z;

    tdhd_axis_lane u_lane_x (
        .sample       (s_tdata[SAMPLE_W-1:0]),
        .enter_thresh (enter_axis_reg),
        .exit_thresh  (exit_xy_reg),
        .cmp          (cmp_x)
    );

    tdhd_axis_lane u_lane_y (
        .sample       (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .enter_thresh (enter_axis_reg),
        .exit_thresh  (exit_xy_reg),
        .cmp          (cmp_y)
    );

    tdhd_axis_lane u_lane_z (
        .sample       (s_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
        .enter_thresh (enter_axis_reg),
        .exit_thresh  (exit_z_reg),
        .cmp          (cmp_z)
    );

    logic         c_valid_reg;
    lane_cmp_t    c_x_reg, c_y_reg, c_z_reg;
    logic         out_ready;
    logic         c_advance;
    logic         s_accept;
    tilt_result_t res;
    tilt_result_t out_reg;
    logic         m_valid_reg;

    assign out_ready = !m_valid_reg || m_tready;
    assign c_advance = c_valid_reg && out_ready;
    assign s_tready  = !c_valid_reg || out_ready;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (s_tready) begin
            c_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            c_x_reg <= cmp_x;
            c_y_reg <= cmp_y;
            c_z_reg <= cmp_z;
        end
    end

    tdhd_merge #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (c_advance),
        .cmp_x       (c_x_reg),
        .cmp_y       (c_y_reg),
        .cmp_z       (c_z_reg),
        .enter_limit (enter_limit_reg),
        .exit_limit  (exit_limit_reg),
        .result      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_reg.sample_class, out_reg.tilt_cleared,
                       out_reg.tilt_entered, out_reg.tilted_flag};

    a_no_double_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(out_reg.tilt_entered && out_reg.tilt_cleared))
        else $error("enter and clear events in one result");

    a_enter_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.tilt_entered) |->
            (out_reg.tilted_flag && out_reg.sample_class == CLASS_TILTED))
        else $error("enter event without tilted flag or tilted sample");

    a_clear_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.tilt_cleared) |->
            (!out_reg.tilted_flag && out_reg.sample_class == CLASS_NORMAL))
        else $error("clear event with flag set or non-normal sample");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (c_valid_reg && !out_ready) |=> c_valid_reg)
        else $error("compare stage dropped a stalled request");

endmodule
